>>> src/mrr_pkg.sv
// ----------------------------------------------------------------------------
// mrr_pkg
// Shared constants, types and the CRC-16 byte step for the read-input slave.
// ----------------------------------------------------------------------------
package mrr_pkg;

  localparam int FRAME_LEN = 8;
  localparam int NUM_REGS  = 16;
  localparam int CNT_W     = $clog2(FRAME_LEN);
  localparam int TBL_AW    = $clog2(NUM_REGS);
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int REPLY_LEN = 7;
  localparam int RIDX_W    = $clog2(REPLY_LEN);

  localparam logic [7:0]  SLAVE_ADDR_RST  = 8'h01;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [7:0]  FUNC_READ_INPUT = 8'h04;
  localparam logic [7:0]  REPLY_COUNT     = 8'h02;
  localparam logic [7:0]  QTY_HI          = 8'h00;
  localparam logic [7:0]  QTY_LO          = 8'h01;

  typedef enum logic [1:0] {
    ST_REPLIED     = 2'd0,
    ST_OTHER_ADDR  = 2'd1,
    ST_CRC_ERROR   = 2'd2,
    ST_UNSUPPORTED = 2'd3
  } frame_status_e;

  typedef enum logic {
    BK_IDLE,
    BK_REPLY
  } back_state_e;

  typedef struct packed {
    frame_status_e status;
    logic [15:0]   value;
  } job_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> src/mrr_in_if.sv
// ----------------------------------------------------------------------------
// mrr_in_if
// Input channel: received line bytes and register table writes.
// ----------------------------------------------------------------------------
interface mrr_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [7:0]  rx_byte;
  logic [3:0]  reg_index;
  logic [15:0] reg_value;

  modport source (output valid, output cmd, output rx_byte, output reg_index,
                  output reg_value, input ready);
  modport sink (input valid, input cmd, input rx_byte, input reg_index,
                input reg_value, output ready);
endinterface

>>> src/mrr_out_if.sv
// ----------------------------------------------------------------------------
// mrr_out_if
// Output channel: reply bytes and frame status results.
// ----------------------------------------------------------------------------
interface mrr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       byte_valid;
  logic       last_of_run;
  logic [1:0] frame_status;

  modport source (output valid, output tx_byte, output byte_valid,
                  output last_of_run, output frame_status, input ready);
  modport sink (input valid, input tx_byte, input byte_valid,
                input last_of_run, input frame_status, output ready);
endinterface

>>> src/mrr_front.sv
// ----------------------------------------------------------------------------
// mrr_front
// Gathers frames, runs the receive CRC, holds the register table and
// classifies each complete frame into a job for the reply side.
// ----------------------------------------------------------------------------
module mrr_front
  import mrr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [7:0]   slave_addr_i,
  mrr_in_if.sink       in_i,
  input  logic         q_full_i,
  output logic         q_push_o,
  output job_t         q_job_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic [15:0]      crc_q, crc_d;
  logic [7:0]       fb_q [FRAME_LEN];
  logic [15:0]      tbl_q [NUM_REGS];

  logic              accept, rx_acc, tbl_we, done;
  logic [TBL_AW-1:0] wr_idx, rd_idx;
  logic [15:0]       rd_val;
  frame_status_e     status;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && !q_full_i;
  assign rx_acc     = accept && !in_i.cmd;
  assign tbl_we     = accept && in_i.cmd && (int'(in_i.reg_index) < NUM_REGS);
  assign done       = rx_acc && (count_q == CNT_W'(FRAME_LEN - 1));
  assign wr_idx     = TBL_AW'(in_i.reg_index);
  assign rd_idx     = TBL_AW'(fb_q[3]);

  always_comb begin
    count_d = count_q;
    crc_d   = crc_q;
    if (rx_acc) begin
      if (done) begin
        count_d = '0;
        crc_d   = CRC_INIT;
      end else begin
        count_d = count_q + 1'b1;
        if (count_q < CNT_W'(FRAME_LEN - 2)) begin
          crc_d = crc_byte(crc_q, in_i.rx_byte);
        end
      end
    end
  end

  always_comb begin
    if (fb_q[0] != slave_addr_i) begin
      status = ST_OTHER_ADDR;
    end else if (fb_q[6] != crc_q[7:0] || in_i.rx_byte != crc_q[15:8]) begin
      status = ST_CRC_ERROR;
    end else if (fb_q[1] != FUNC_READ_INPUT || fb_q[4] != QTY_HI || fb_q[5] != QTY_LO) begin
      status = ST_UNSUPPORTED;
    end else begin
      status = ST_REPLIED;
    end
    rd_val = (int'(fb_q[3]) < NUM_REGS) ? tbl_q[rd_idx] : 16'h0000;
  end

  assign q_push_o       = done;
  assign q_job_o.status = status;
  assign q_job_o.value  = rd_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      crc_q   <= CRC_INIT;
    end else begin
      count_q <= count_d;
      crc_q   <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_acc) begin
      fb_q[count_q] <= in_i.rx_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        tbl_q[i] <= 16'h0000;
      end
    end else if (tbl_we) begin
      tbl_q[wr_idx] <= in_i.reg_value;
    end
  end

endmodule

>>> src/mrr_queue.sv
// ----------------------------------------------------------------------------
// mrr_queue
// Short job queue between the frame classifier and the reply generator.
// ----------------------------------------------------------------------------
module mrr_queue
  import mrr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t job_o
);

  job_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == (QPTR_W + 1)'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

>>> src/mrr_back.sv
// ----------------------------------------------------------------------------
// mrr_back
// Turns jobs into results: one status result, or a seven byte reply, its CRC
// computed one byte per unstalled cycle, through a registered output stage.
// ----------------------------------------------------------------------------
module mrr_back
  import mrr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [7:0]   slave_addr_i,
  input  logic         q_valid_i,
  input  job_t         q_job_i,
  output logic         q_pop_o,
  mrr_out_if.source    out_o
);

  back_state_e       state_q, state_d;
  logic [RIDX_W-1:0] idx_q, idx_d;
  logic [15:0]       crc_q, crc_d;
  logic [15:0]       val_q, val_d;
  logic              ovalid_q, ovalid_d;
  logic [7:0]        tx_q, tx_d;
  logic              bv_q, bv_d;
  logic              last_q, last_d;
  frame_status_e     st_q, st_d;
  logic              adv;
  logic [7:0]        cur_byte;

  assign adv = !ovalid_q || out_o.ready;

  always_comb begin
    case (idx_q)
      RIDX_W'(1): cur_byte = FUNC_READ_INPUT;
      RIDX_W'(2): cur_byte = REPLY_COUNT;
      RIDX_W'(3): cur_byte = val_q[15:8];
      RIDX_W'(4): cur_byte = val_q[7:0];
      RIDX_W'(5): cur_byte = crc_q[7:0];
      RIDX_W'(6): cur_byte = crc_q[15:8];
      default:    cur_byte = slave_addr_i;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    crc_d    = crc_q;
    val_d    = val_q;
    ovalid_d = ovalid_q;
    tx_d     = tx_q;
    bv_d     = bv_q;
    last_d   = last_q;
    st_d     = st_q;
    q_pop_o  = 1'b0;
    if (adv) begin
      ovalid_d = 1'b0;
      case (state_q)
        BK_IDLE: begin
          if (q_valid_i) begin
            q_pop_o  = 1'b1;
            ovalid_d = 1'b1;
            st_d     = q_job_i.status;
            if (q_job_i.status != ST_REPLIED) begin
              tx_d   = 8'h00;
              bv_d   = 1'b0;
              last_d = 1'b1;
            end else begin
              tx_d    = slave_addr_i;
              bv_d    = 1'b1;
              last_d  = 1'b0;
              val_d   = q_job_i.value;
              crc_d   = crc_byte(CRC_INIT, slave_addr_i);
              idx_d   = RIDX_W'(1);
              state_d = BK_REPLY;
            end
          end
        end
        BK_REPLY: begin
          ovalid_d = 1'b1;
          tx_d     = cur_byte;
          bv_d     = 1'b1;
          st_d     = ST_REPLIED;
          last_d   = (idx_q == RIDX_W'(REPLY_LEN - 1));
          if (idx_q < RIDX_W'(REPLY_LEN - 2)) begin
            crc_d = crc_byte(crc_q, cur_byte);
          end
          if (idx_q == RIDX_W'(REPLY_LEN - 1)) begin
            idx_d   = '0;
            state_d = BK_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        default: begin
          state_d = BK_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_IDLE;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q  <= crc_d;
    val_q  <= val_d;
    tx_q   <= tx_d;
    bv_q   <= bv_d;
    last_q <= last_d;
    st_q   <= st_d;
  end

  assign out_o.valid        = ovalid_q;
  assign out_o.tx_byte      = tx_q;
  assign out_o.byte_valid   = bv_q;
  assign out_o.last_of_run  = last_q;
  assign out_o.frame_status = st_q;

endmodule

>>> src/modbus_rtu_read_input_slave_top.sv
// ----------------------------------------------------------------------------
// modbus_rtu_read_input_slave_top
// Modbus RTU slave answering function 4 for a single input register.
// ----------------------------------------------------------------------------
// The block accepts one input transaction per cycle, either a received line
// byte or a register table write, and stalls input only when its two-entry
// job queue is full. Every eighth line byte closes a frame; the frame is
// classified in the cycle it completes. A rejected frame produces one status
// transaction, and a good frame produces seven reply byte transactions at one
// per unstalled cycle, with the reply CRC computed one byte per cycle in the
// output generator. The station address register resets to 1.
module modbus_rtu_read_input_slave_top
  import mrr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i,
  mrr_in_if.sink     in_i,
  mrr_out_if.source  out_o
);

  logic [7:0] slave_addr_q;
  logic       q_push, q_full, q_pop, q_valid;
  job_t       push_job, pop_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= SLAVE_ADDR_RST;
    end else if (cfg_we_i) begin
      slave_addr_q <= cfg_data_i;
    end
  end

  mrr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .slave_addr_i (slave_addr_q),
    .in_i         (in_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_job_o      (push_job)
  );

  mrr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .job_o   (pop_job)
  );

  mrr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .slave_addr_i (slave_addr_q),
    .q_valid_i    (q_valid),
    .q_job_i      (pop_job),
    .q_pop_o      (q_pop),
    .out_o        (out_o)
  );

endmodule

>>> src/mrr_checker.sv
// ----------------------------------------------------------------------------
// mrr_checker
// Port-level checks on the result stream of the read-input slave.
// ----------------------------------------------------------------------------
module mrr_checker
  import mrr_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] tx_byte_i,
  input logic       byte_valid_i,
  input logic       last_of_run_i,
  input logic [1:0] frame_status_i
);

  a_status_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !byte_valid_i |-> last_of_run_i)
    else $error("status transaction not marked last");

  a_status_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !byte_valid_i |-> tx_byte_i == 8'h00 && frame_status_i != ST_REPLIED)
    else $error("status transaction carries a byte or a replied status");

  a_reply_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && byte_valid_i |-> frame_status_i == ST_REPLIED)
    else $error("reply byte with a failure status");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(tx_byte_i)
      && $stable(last_of_run_i))
    else $error("stalled result changed");

endmodule

bind modbus_rtu_read_input_slave_top mrr_checker u_mrr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .tx_byte_i      (out_o.tx_byte),
  .byte_valid_i   (out_o.byte_valid),
  .last_of_run_i  (out_o.last_of_run),
  .frame_status_i (out_o.frame_status)
);

>>> verif/modbus_rtu_read_input_slave_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_rtu_read_input_slave_top_tb
// Self-checking testbench for the function 4 read-input slave. It sends
// received line bytes and register table writes, predicts every reply byte
// and status transaction, and checks each one in order. Directed frames cover
// the table extremes, unknown registers, every rejection and the station
// address settings. A long receiver hold-off follows; random frames, mostly well
// formed, come last under phases of random idling on one, both or no channel.
// ----------------------------------------------------------------------------
module modbus_rtu_read_input_slave_top_tb;
  import mrr_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 11;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 150;
  localparam int RANDOM_ITEMS = 80;
  localparam int MAX_REPORTS  = 10;
  localparam int TIMEOUT_NS   = 2_400_000;

  typedef struct packed {
    logic [7:0]    tx_byte;
    logic          byte_valid;
    logic          last_of_run;
    frame_status_e status;
  } tx_result_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_data;

  mrr_in_if  in_if ();
  mrr_out_if out_if ();

  modbus_rtu_read_input_slave_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  logic [7:0]  station_addr;
  logic [7:0]  rx_frame [FRAME_LEN];
  int          rx_count;
  logic [15:0] rx_crc;
  logic [15:0] reg_table [NUM_REGS];

  tx_result_t pending_replies [$];
  int         mismatch_count;
  int         items_sent;
  bit         in_idle_en;
  bit         out_idle_en;
  int         hold_cycles;

  function automatic logic [15:0] crc16_modbus(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] acc;
    acc = crc ^ {8'h00, data};
    repeat (8) begin
      acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
    end
    return acc;
  endfunction

  function automatic void push_status(input frame_status_e st);
    tx_result_t r;
    r = '{tx_byte: 8'h00, byte_valid: 1'b0, last_of_run: 1'b1, status: st};
    pending_replies.push_back(r);
  endfunction

  function automatic void predict_response(input logic cmd, input logic [7:0] rx,
                                           input logic [3:0] idx, input logic [15:0] val);
    logic [15:0] crc;
    logic [15:0] word;
    logic [7:0]  reply [REPLY_LEN];
    tx_result_t  r;
    if (cmd) begin
      if (int'(idx) < NUM_REGS) reg_table[idx] = val;
      return;
    end
    rx_frame[rx_count] = rx;
    if (rx_count < 6) rx_crc = crc16_modbus(rx_crc, rx);
    if (rx_count < FRAME_LEN - 1) begin
      rx_count++;
      return;
    end
    crc      = rx_crc;
    rx_count = 0;
    rx_crc   = CRC_INIT;
    if (rx_frame[0] != station_addr) begin
      push_status(ST_OTHER_ADDR);
    end else if (rx_frame[6] != crc[7:0] || rx_frame[7] != crc[15:8]) begin
      push_status(ST_CRC_ERROR);
    end else if (rx_frame[1] != FUNC_READ_INPUT || rx_frame[4] != QTY_HI ||
                 rx_frame[5] != QTY_LO) begin
      push_status(ST_UNSUPPORTED);
    end else begin
      word     = (int'(rx_frame[3]) < NUM_REGS) ? reg_table[rx_frame[3]] : 16'h0000;
      reply[0] = station_addr;
      reply[1] = FUNC_READ_INPUT;
      reply[2] = REPLY_COUNT;
      reply[3] = word[15:8];
      reply[4] = word[7:0];
      crc      = CRC_INIT;
      for (int i = 0; i < 5; i++) crc = crc16_modbus(crc, reply[i]);
      reply[5] = crc[7:0];
      reply[6] = crc[15:8];
      for (int i = 0; i < REPLY_LEN; i++) begin
        r = '{tx_byte: reply[i], byte_valid: 1'b1, last_of_run: (i == REPLY_LEN - 1),
              status: ST_REPLIED};
        pending_replies.push_back(r);
      end
    end
  endfunction

  task automatic drive_item(input logic cmd, input logic [7:0] rx, input logic [3:0] idx,
                            input logic [15:0] val);
    int gap;
    gap = in_idle_en ? $urandom_range(0, 14) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.cmd       <= cmd;
    in_if.rx_byte   <= rx;
    in_if.reg_index <= idx;
    in_if.reg_value <= val;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_response(cmd, rx, idx, val);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    drive_item(1'b0, b, 4'($urandom), 16'($urandom));
  endtask

  task automatic write_register(input logic [3:0] idx, input logic [15:0] val);
    drive_item(1'b1, 8'($urandom), idx, val);
  endtask

  task automatic send_frame(input logic [7:0] addr, input logic [7:0] func,
                            input logic [7:0] start_hi, input logic [7:0] start_lo,
                            input logic [7:0] qty_hi, input logic [7:0] qty_lo,
                            input logic [15:0] crc_err, input bit mix);
    logic [7:0]  fb [FRAME_LEN];
    logic [15:0] crc;
    fb[0] = addr;
    fb[1] = func;
    fb[2] = start_hi;
    fb[3] = start_lo;
    fb[4] = qty_hi;
    fb[5] = qty_lo;
    crc   = CRC_INIT;
    for (int i = 0; i < 6; i++) crc = crc16_modbus(crc, fb[i]);
    crc   = crc ^ crc_err;
    fb[6] = crc[7:0];
    fb[7] = crc[15:8];
    for (int i = 0; i < FRAME_LEN; i++) begin
      if (mix && $urandom_range(0, 3) == 0) write_register(4'($urandom), 16'($urandom));
      send_byte(fb[i]);
    end
  endtask

  task automatic read_register(input logic [7:0] start_hi, input logic [7:0] start_lo,
                               input bit mix);
    send_frame(station_addr, FUNC_READ_INPUT, start_hi, start_lo, QTY_HI, QTY_LO, 16'h0000,
               mix);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_station_address(input logic [7:0] addr);
    wait_drain();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= addr;
    @(negedge clk);
    cfg_we   <= 1'b0;
    station_addr = addr;
  endtask

  task automatic test_reset_values();
    read_register(8'h00, 8'd15, 1'b0);
  endtask

  task automatic test_register_table();
    write_register(4'd0, 16'hFFFF);
    write_register(4'd15, 16'h8001);
    read_register(8'h00, 8'd0, 1'b1);
    read_register(8'hFF, 8'd15, 1'b0);
    read_register(8'hFF, 8'd200, 1'b0);
  endtask

  task automatic test_frame_rejects();
    send_frame(station_addr ^ 8'h02, FUNC_READ_INPUT, 8'h00, 8'd1, QTY_HI, QTY_LO, 16'h0001,
               1'b0);
    send_frame(station_addr, FUNC_READ_INPUT, 8'h00, 8'd1, QTY_HI, QTY_LO, 16'h0001, 1'b0);
    send_frame(station_addr, FUNC_READ_INPUT, 8'h00, 8'd1, QTY_HI, QTY_LO, 16'h8000, 1'b0);
    send_frame(station_addr, 8'h03, 8'h00, 8'd1, QTY_HI, QTY_LO, 16'h0000, 1'b0);
    send_frame(station_addr, FUNC_READ_INPUT, 8'h00, 8'd1, 8'h01, QTY_LO, 16'h0000, 1'b0);
    send_frame(station_addr, FUNC_READ_INPUT, 8'h00, 8'd1, QTY_HI, 8'h00, 16'h0000, 1'b0);
  endtask

  task automatic test_station_address();
    set_station_address(8'h00);
    read_register(8'h00, 8'd0, 1'b0);
    send_frame(8'h01, FUNC_READ_INPUT, 8'h00, 8'd0, QTY_HI, QTY_LO, 16'h0000, 1'b0);
    set_station_address(8'hFF);
    read_register(8'h00, 8'd15, 1'b0);
  endtask

  task automatic test_backpressure();
    wait_drain();
    in_idle_en  = 1'b0;
    hold_cycles = HOLD_CYCLES;
    for (int i = 0; i < 5; i++) read_register(8'($urandom), 8'($urandom_range(0, 15)), 1'b0);
    wait_drain();
  endtask

  task automatic random_frame();
    int          choice;
    int          n;
    logic [7:0]  func;
    logic [7:0]  qty_hi;
    logic [7:0]  qty_lo;
    logic [7:0]  start_lo;
    choice   = $urandom_range(0, 99);
    start_lo = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 15))
                                            : 8'($urandom_range(16, 255));
    if (choice < 55) begin
      read_register(8'($urandom), start_lo, $urandom_range(0, 3) == 0);
    end else if (choice < 63) begin
      send_frame(station_addr ^ 8'($urandom_range(1, 255)), FUNC_READ_INPUT, 8'($urandom),
                 start_lo, QTY_HI, QTY_LO, 16'h0000, 1'b0);
    end else if (choice < 71) begin
      send_frame(station_addr, FUNC_READ_INPUT, 8'($urandom), start_lo, QTY_HI, QTY_LO,
                 16'($urandom_range(1, 65535)), $urandom_range(0, 3) == 0);
    end else if (choice < 81) begin
      func   = FUNC_READ_INPUT;
      qty_hi = QTY_HI;
      qty_lo = QTY_LO;
      case ($urandom_range(0, 2))
        0: func = FUNC_READ_INPUT ^ 8'($urandom_range(1, 255));
        1: qty_hi = 8'($urandom_range(1, 255));
        default: qty_lo = QTY_LO ^ 8'($urandom_range(1, 255));
      endcase
      send_frame(station_addr, func, 8'($urandom), start_lo, qty_hi, qty_lo, 16'h0000, 1'b0);
    end else if (choice < 91) begin
      n = $urandom_range(1, 3);
      repeat (n) write_register(4'($urandom), 16'($urandom));
    end else begin
      n = $urandom_range(1, 7);
      repeat (n) send_byte(8'($urandom));
      while (rx_count != 0) send_byte(8'($urandom));
    end
  endtask

  task automatic test_random_traffic();
    int target;
    target = items_sent;
    for (int p = 0; p < 4; p++) begin
      set_station_address(8'($urandom));
      in_idle_en  = (p == 0 || p == 2);
      out_idle_en = (p == 0 || p == 3);
      target += RANDOM_ITEMS / 4;
      while (items_sent < target) random_frame();
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  initial begin
    #TIMEOUT_NS;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int stall;
    out_if.ready = 1'b0;
    wait (rst_n);
    forever begin
      stall = out_idle_en ? $urandom_range(0, 14) : 0;
      if (hold_cycles > 0) begin
        stall       = hold_cycles;
        hold_cycles = 0;
      end
      @(negedge clk);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    tx_result_t got;
    tx_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = '{tx_byte: out_if.tx_byte, byte_valid: out_if.byte_valid,
              last_of_run: out_if.last_of_run, status: frame_status_e'(out_if.frame_status)};
      if (pending_replies.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected transaction tx=%h valid=%b last=%b status=%0d", $realtime,
                   got.tx_byte, got.byte_valid, got.last_of_run, got.status);
      end else begin
        want = pending_replies.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: expected tx=%h valid=%b last=%b status=%0d,", $realtime,
                     want.tx_byte, want.byte_valid, want.last_of_run, want.status,
                     " got tx=%h valid=%b last=%b status=%0d",
                     got.tx_byte, got.byte_valid, got.last_of_run, got.status);
        end
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_data        = 8'h00;
    in_if.valid     = 1'b0;
    in_if.cmd       = 1'b0;
    in_if.rx_byte   = 8'h00;
    in_if.reg_index = 4'h0;
    in_if.reg_value = 16'h0000;
    station_addr    = SLAVE_ADDR_RST;
    rx_count        = 0;
    rx_crc          = CRC_INIT;
    foreach (reg_table[i]) reg_table[i] = 16'h0000;
    foreach (rx_frame[i]) rx_frame[i] = 8'h00;
    mismatch_count  = 0;
    items_sent      = 0;
    in_idle_en      = 1'b1;
    out_idle_en     = 1'b1;
    hold_cycles     = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_register_table();
    test_frame_rejects();
    test_station_address();
    test_backpressure();
    test_random_traffic();

    wait_drain();
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/mrr_pkg.sv
src/mrr_in_if.sv
src/mrr_out_if.sv
src/mrr_front.sv
src/mrr_queue.sv
src/mrr_back.sv
src/modbus_rtu_read_input_slave_top.sv
src/mrr_checker.sv
verif/modbus_rtu_read_input_slave_top_tb.sv
